[hw/rtl/cesd_pkg.sv]
`default_nettype none

package cesd_pkg;

  // decoder phase codes
  typedef enum logic [2:0] {
    PH_PLAIN  = 3'd0,
    PH_BSLASH = 3'd1,
    PH_OCT1   = 3'd2,
    PH_OCT2   = 3'd3,
    PH_CLOSED = 3'd4
  } phase_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_OPEN  = 3'd1,
    ST_JUNK     = 3'd2,
    ST_BAD_ESC  = 3'd3,
    ST_OCT_BIG  = 3'd4,
    ST_DANGLING = 3'd5,
    ST_FAILED   = 3'd6
  } status_e;

  // item kinds carried on the input tuser
  localparam logic OpData = 1'b0;
  localparam logic OpEnd  = 1'b1;

  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5c;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharSeven     = 8'h37;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] OctLimit      = 8'd32;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  // decoder state carried between beats
  typedef struct packed {
    phase_e     phase;
    logic       await_open;
    logic [7:0] octal;
    logic       failed;
  } dec_state_t;

  // one decoded result
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] first;
    logic [7:0] second;
    status_e    status;
  } dec_result_t;

  // simple escape letters: returns {valid, value}
  function automatic logic [8:0] esc_lookup(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h61:   r = {1'b1, 8'd7};   // a
      8'h62:   r = {1'b1, 8'd8};   // b
      8'h66:   r = {1'b1, 8'd12};  // f
      8'h6e:   r = {1'b1, 8'd10};  // n
      8'h72:   r = {1'b1, 8'd13};  // r
      8'h74:   r = {1'b1, 8'd9};   // t
      8'h76:   r = {1'b1, 8'd11};  // v
      8'h27, 8'h22, 8'h5c, 8'h3f: r = {1'b1, b};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= CharZero) && (b <= CharSeven);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CharSpace) || ((b >= 8'd9) && (b <= 8'd13));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cesd_step.sv]
`default_nettype none

module cesd_step (
  input  cesd_pkg::dec_state_t  state_i,
  input  logic                  strip_i,
  input  logic                  op_i,
  input  logic [7:0]            byte_i,
  output cesd_pkg::dec_state_t  state_o,
  output cesd_pkg::dec_result_t result_o
);
  import cesd_pkg::*;

  dec_state_t  nxt;
  dec_result_t res;
  logic        plain_go;
  logic [8:0]  esc;
  logic [7:0]  oct_next;

  assign esc      = esc_lookup(byte_i);
  assign oct_next = {state_i.octal[4:0], byte_i[2:0]};

  // one decode step
  always_comb begin
    nxt        = state_i;
    res.count  = 2'd0;
    res.first  = 8'd0;
    res.second = 8'd0;
    res.status = ST_OK;
    plain_go   = 1'b0;

    if (op_i == OpEnd) begin
      if (state_i.failed) begin
        res.status = ST_FAILED;
      end else if (state_i.phase == PH_BSLASH) begin
        res.status = ST_DANGLING;
      end else if (state_i.phase == PH_OCT1 || state_i.phase == PH_OCT2) begin
        res.count = 2'd1;
        res.first = state_i.octal;
      end
      // re-arm for the next string
      nxt.phase      = PH_PLAIN;
      nxt.octal      = 8'd0;
      nxt.failed     = 1'b0;
      nxt.await_open = strip_i;
    end else if (state_i.failed) begin
      res.status = ST_FAILED;
    end else if (state_i.await_open) begin
      nxt.await_open = 1'b0;
      if (byte_i != CharQuote) begin
        res.status = ST_NO_OPEN;
        nxt.failed = 1'b1;
      end
    end else begin
      case (state_i.phase)
        PH_BSLASH: begin
          if (esc[8]) begin
            res.count = 2'd1;
            res.first = esc[7:0];
            nxt.phase = PH_PLAIN;
          end else if (is_octal(byte_i)) begin
            nxt.octal = {5'd0, byte_i[2:0]};
            nxt.phase = PH_OCT1;
          end else begin
            res.status = ST_BAD_ESC;
            nxt.failed = 1'b1;
          end
        end
        PH_OCT1: begin
          if (is_octal(byte_i)) begin
            nxt.octal = oct_next;
            nxt.phase = PH_OCT2;
          end else begin
            res.count = 2'd1;
            res.first = state_i.octal;
            nxt.phase = PH_PLAIN;
            plain_go  = 1'b1;
          end
        end
        PH_OCT2: begin
          if (is_octal(byte_i)) begin
            if (state_i.octal >= OctLimit) begin
              res.status = ST_OCT_BIG;
              nxt.failed = 1'b1;
            end else begin
              nxt.octal = oct_next;
              res.count = 2'd1;
              res.first = oct_next;
              nxt.phase = PH_PLAIN;
            end
          end else begin
            res.count = 2'd1;
            res.first = state_i.octal;
            nxt.phase = PH_PLAIN;
            plain_go  = 1'b1;
          end
        end
        PH_CLOSED: begin
          if (!is_space(byte_i)) begin
            res.status = ST_JUNK;
            nxt.failed = 1'b1;
          end
        end
        default: begin
          nxt.phase = PH_PLAIN;
          plain_go  = 1'b1;
        end
      endcase

      // byte handled as plain text, possibly after an octal flush
      if (plain_go) begin
        if (strip_i && byte_i == CharQuote) begin
          nxt.phase = PH_CLOSED;
        end else if (byte_i == CharBackslash) begin
          nxt.phase = PH_BSLASH;
        end else if (res.count == 2'd0) begin
          res.count = 2'd1;
          res.first = byte_i;
        end else begin
          res.count  = 2'd2;
          res.second = byte_i;
        end
      end
    end
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

`default_nettype wire

[hw/rtl/c_string_escape_decoder_top.sv]
// C string literal unescape decoder.
// Input stream: one raw byte per beat on s_axis_tdata; s_axis_tuser high
// marks an end-of-string beat (data ignored) that flushes a pending octal
// escape or reports a dangling backslash, then re-arms the decoder.
// Output stream: exactly one result beat per input beat, carrying 0 to 2
// decoded bytes, the byte count and a status code. Errors are sticky until
// the next end-of-string beat.
// Configuration: cfg_we_i writes cfg_wdata_i into the strip-quotes bit
// (require and drop surrounding double quotes); write only while idle.
// Path: each input beat is taken into the input register, and its result
// is then held in the result register and presented from there.
// Throughput: one beat per cycle while m_axis_tready is high; the decoder
// state update is one short combinational step between the two registers.
// Reset: quote stripping off, decoder in plain text, no error, both
// pipeline registers empty.
// Stall: when m_axis_tready is low the result register holds, the input
// register still fills once, and s_axis_tready then drops until the
// result is taken.
`default_nettype none

module c_string_escape_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cesd_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] operation
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] byte_count, [9:2] first_byte, [17:10] second_byte, [20:18] status
  output logic [cesd_pkg::OutDataW-1:0] m_axis_tdata
);
  import cesd_pkg::*;

  logic        strip_q;
  dec_state_t  state_q, state_d;
  logic        in_valid_q;
  logic        in_op_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  dec_result_t out_q, res_d;
  logic        adv;

  // result register free or draining this cycle
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || adv;

  cesd_step u_step (
    .state_i  (state_q),
    .strip_i  (strip_q),
    .op_i     (in_op_q),
    .byte_i   (in_byte_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // decoder state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q <= 1'b0;
      state_q <= '{phase: PH_PLAIN, await_open: 1'b0, octal: 8'd0, failed: 1'b0};
    end else begin
      if (in_valid_q && adv) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        strip_q            <= cfg_wdata_i;
        state_q.await_open <= cfg_wdata_i;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_q) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_q.status, out_q.second, out_q.first, out_q.count};

endmodule

`default_nettype wire

[sim/c_string_escape_decoder_top_tb.sv]
`default_nettype none

module c_string_escape_decoder_top_tb;
  import cesd_pkg::*;

  // one raw input beat: kind and byte
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } char_beat_t;

  localparam int StuckLimit = 2000;

  // letters accepted after a backslash as single-character escapes
  localparam logic [7:0] EscChars [11] = '{"a", "b", "f", "n", "r", "t", "v", "'", "\"",
                                           "\\", "?"};
  // bytes allowed after the closing quote
  localparam logic [7:0] WsChars [6] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, CharSpace};

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // stimulus and expected decoded results
  char_beat_t  raw_q[$];
  dec_result_t decoded_q[$];

  // decoder state mirrored by the testbench
  logic       strip_q;
  logic       await_q;
  logic       failed_q;
  phase_e     phase_q;
  logic [7:0] octal_q;
  logic [1:0] out_cnt;
  logic [7:0] out_b0;
  logic [7:0] out_b1;

  int src_idle_pct;
  int rcv_idle_pct;
  int n_queued;
  int n_in;
  int n_out;
  int n_pairs;
  int n_err;
  int n_cfg;
  int n_mismatch;
  int stuck_cycles;

  c_string_escape_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // append a decoded byte to the current result
  function automatic void put_byte(input logic [7:0] v);
    if (out_cnt == 2'd0) out_b0 = v;
    else out_b1 = v;
    if (out_cnt < 2'd2) out_cnt = out_cnt + 2'd1;
  endfunction

  // ordinary text: closing quote, start of escape or literal byte
  function automatic void text_byte(input logic [7:0] v);
    if (strip_q && v == CharQuote) phase_q = PH_CLOSED;
    else if (v == CharBackslash) phase_q = PH_BSLASH;
    else put_byte(v);
  endfunction

  // one data byte through the escape state machine
  function automatic status_e data_beat(input logic [7:0] v);
    status_e st;
    logic    oct;
    st  = ST_OK;
    oct = (v >= CharZero) && (v <= CharSeven);
    if (await_q) begin
      await_q = 1'b0;
      if (v != CharQuote) begin
        failed_q = 1'b1;
        st = ST_NO_OPEN;
      end
    end else begin
      case (phase_q)
        PH_BSLASH: begin
          phase_q = PH_PLAIN;
          case (v)
            "a": put_byte(8'd7);
            "b": put_byte(8'd8);
            "f": put_byte(8'd12);
            "n": put_byte(8'd10);
            "r": put_byte(8'd13);
            "t": put_byte(8'd9);
            "v": put_byte(8'd11);
            "'", CharQuote, CharBackslash, "?": put_byte(v);
            default: begin
              if (oct) begin
                octal_q = v - CharZero;
                phase_q = PH_OCT1;
              end else begin
                phase_q = PH_BSLASH;
                failed_q = 1'b1;
                st = ST_BAD_ESC;
              end
            end
          endcase
        end
        PH_OCT1: begin
          if (oct) begin
            octal_q = (octal_q << 3) + (v - CharZero);
            phase_q = PH_OCT2;
          end else begin
            put_byte(octal_q);
            phase_q = PH_PLAIN;
            text_byte(v);
          end
        end
        PH_OCT2: begin
          if (oct) begin
            if (octal_q >= OctLimit) begin
              failed_q = 1'b1;
              st = ST_OCT_BIG;
            end else begin
              octal_q = (octal_q << 3) + (v - CharZero);
              put_byte(octal_q);
              phase_q = PH_PLAIN;
            end
          end else begin
            put_byte(octal_q);
            phase_q = PH_PLAIN;
            text_byte(v);
          end
        end
        PH_CLOSED: begin
          if (!(v == CharSpace || (v >= 8'd9 && v <= 8'd13))) begin
            failed_q = 1'b1;
            st = ST_JUNK;
          end
        end
        default: begin
          phase_q = PH_PLAIN;
          text_byte(v);
        end
      endcase
    end
    return st;
  endfunction

  // expected result of one accepted beat, advances the mirrored state
  function automatic dec_result_t decode_beat(input logic op, input logic [7:0] v);
    dec_result_t r;
    status_e     st;
    out_cnt = 2'd0;
    out_b0  = 8'd0;
    out_b1  = 8'd0;
    if (op == OpEnd) begin
      if (failed_q) st = ST_FAILED;
      else if (phase_q == PH_BSLASH) st = ST_DANGLING;
      else begin
        if (phase_q == PH_OCT1 || phase_q == PH_OCT2) put_byte(octal_q);
        st = ST_OK;
      end
      // re-arm for the next string
      phase_q  = PH_PLAIN;
      octal_q  = 8'd0;
      failed_q = 1'b0;
      await_q  = strip_q;
    end else if (failed_q) begin
      st = ST_FAILED;
    end else begin
      st = data_beat(v);
      if (st != ST_OK) begin
        out_cnt = 2'd0;
        out_b0  = 8'd0;
        out_b1  = 8'd0;
      end
    end
    r.count  = out_cnt;
    r.first  = out_b0;
    r.second = out_b1;
    r.status = st;
    return r;
  endfunction

  function automatic void queue_beat(input logic op, input logic [7:0] v);
    raw_q.push_back('{op: op, data: v});
    n_queued++;
  endfunction

  // one random string: mostly well formed, with some noise and broken escapes
  function automatic void gen_string();
    int         k;
    int         tok;
    int         d;
    int         i;
    logic [7:0] b;
    if (strip_q) begin
      if ($urandom_range(0, 9) != 0) queue_beat(OpData, CharQuote);
      else queue_beat(OpData, 8'($urandom_range(0, 255)));
    end
    k = $urandom_range(0, 12);
    repeat (k) begin
      tok = $urandom_range(0, 9);
      case (tok)
        0, 1, 2, 3: begin
          b = 8'($urandom_range(0, 255));
          if (b == CharBackslash || (strip_q && b == CharQuote)) b = "A";
          queue_beat(OpData, b);
        end
        4: begin
          queue_beat(OpData, CharBackslash);
          queue_beat(OpData, EscChars[$urandom_range(0, 10)]);
        end
        5, 6, 7: begin
          // octal escape, mostly in range when three digits long
          d = $urandom_range(1, 3);
          queue_beat(OpData, CharBackslash);
          for (i = 0; i < d; i++) begin
            b = CharZero + 8'($urandom_range(0, 7));
            if (i == 0 && d == 3 && $urandom_range(0, 7) != 0)
              b = CharZero + 8'($urandom_range(0, 3));
            queue_beat(OpData, b);
          end
        end
        8: begin
          queue_beat(OpData, CharBackslash);
          queue_beat(OpData, 8'($urandom_range(0, 255)));
        end
        default: queue_beat(OpData, 8'($urandom_range(0, 255)));
      endcase
    end
    // closing quote, trailing whitespace and now and then junk
    if (strip_q && $urandom_range(0, 9) != 0) begin
      queue_beat(OpData, CharQuote);
      repeat ($urandom_range(0, 3)) queue_beat(OpData, WsChars[$urandom_range(0, 5)]);
      if ($urandom_range(0, 9) == 0) queue_beat(OpData, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) != 0) queue_beat(OpEnd, 8'($urandom_range(0, 255)));
  endfunction

  // wait until every beat is sent and every result is back
  task automatic wait_idle();
    @(negedge clk_i);
    while (raw_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_strip(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    strip_q = v;
    await_q = v;
    n_cfg++;
  endtask

  // input driver, predicts each accepted beat
  always @(posedge clk_i) begin : drive_in
    char_beat_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decoded_q.push_back(decode_beat(s_axis_tuser, s_axis_tdata));
        n_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (raw_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = raw_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.op;
          s_axis_tdata  <= nxt.data;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // result monitor
  always @(posedge clk_i) begin : check_out
    dec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_out++;
      if (decoded_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result beat: tdata=%h", m_axis_tdata);
      end else begin
        want = decoded_q.pop_front();
        if (want.count == 2'd2) n_pairs++;
        if (want.status != ST_OK) n_err++;
        if (m_axis_tdata[1:0] !== want.count || m_axis_tdata[9:2] !== want.first ||
            m_axis_tdata[17:10] !== want.second || m_axis_tdata[20:18] !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("result %0d mismatch: count %0d/%0d first %h/%h second %h/%h status %0d/%0d",
                     n_out, m_axis_tdata[1:0], want.count, m_axis_tdata[9:2], want.first,
                     m_axis_tdata[17:10], want.second, m_axis_tdata[20:18], want.status);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("timeout after %0d cycles with no beat accepted", stuck_cycles);
      $display("c_string_escape_decoder_top regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin : stim
    int phase_i;
    int chunk_i;
    int target;
    strip_q      = 1'b0;
    await_q      = 1'b0;
    failed_q     = 1'b0;
    phase_q      = PH_PLAIN;
    octal_q      = 8'd0;
    src_idle_pct = 28;
    rcv_idle_pct = 52;
    n_queued = 0; n_in = 0; n_out = 0; n_pairs = 0; n_err = 0; n_cfg = 0;
    n_mismatch = 0;
    stuck_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // quotes off: byte extremes and a bare quote as plain text
    queue_beat(OpData, 8'h00);
    queue_beat(OpData, 8'hff);
    queue_beat(OpData, CharQuote);
    // simple escape, then a one-digit octal ended by a letter
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "n");
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "1");
    queue_beat(OpData, "x");
    // largest three-digit octal
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "3");
    queue_beat(OpData, "7");
    queue_beat(OpData, "7");
    // octal overflow, sticky error, end while failed
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "4");
    queue_beat(OpData, "0");
    queue_beat(OpData, "0");
    queue_beat(OpData, "A");
    queue_beat(OpEnd, 8'hff);
    // dangling backslash, then an octal flushed by the end beat
    queue_beat(OpData, CharBackslash);
    queue_beat(OpEnd, 8'h00);
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "7");
    queue_beat(OpEnd, 8'h00);
    // unknown escape letter
    queue_beat(OpData, CharBackslash);
    queue_beat(OpData, "q");
    queue_beat(OpEnd, 8'h00);
    wait_idle();

    // quotes on: missing open quote, then junk after the close
    write_strip(1'b1);
    queue_beat(OpData, "a");
    queue_beat(OpEnd, 8'h00);
    queue_beat(OpData, CharQuote);
    queue_beat(OpData, "h");
    queue_beat(OpData, CharQuote);
    queue_beat(OpData, CharSpace);
    queue_beat(OpData, "z");
    queue_beat(OpEnd, 8'h00);

    // random strings under three idle patterns and changing quote mode
    for (phase_i = 0; phase_i < 3; phase_i++) begin
      wait_idle();
      case (phase_i)
        0: begin src_idle_pct = 28; rcv_idle_pct = 52; end
        1: begin src_idle_pct = 52; rcv_idle_pct = 28; end
        default: begin src_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (chunk_i = 0; chunk_i < 3; chunk_i++) begin
        wait_idle();
        if (chunk_i == 0) write_strip(phase_i[0]);
        else write_strip(1'($urandom_range(0, 1)));
        target = n_queued + 100;
        while (n_queued < target) gen_string();
      end
    end

    wait_idle();
    $display("decoded %0d input beats into %0d results over %0d quote mode writes", n_in,
             n_out, n_cfg);
    $display("%0d results carried two bytes, %0d reported an error, %0d mismatches", n_pairs,
             n_err, n_mismatch);
    if (n_mismatch == 0 && decoded_q.size() == 0) begin
      $display("c_string_escape_decoder_top regression: pass");
    end else begin
      $display("c_string_escape_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
